// ===== src/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, case codes and sideband types for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int CoefW   = 32;
  localparam int RootW   = 64;
  localparam int DiscW   = 66;
  localparam int RadW    = 100;
  localparam int SqrtN   = RadW / 2;
  localparam int SqRemW  = SqrtN + 2;
  localparam int NumW    = 67;
  localparam int DenW    = 32;
  localparam int NegW    = 52;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_INF  = 3'd1,
    KIND_LIN  = 3'd2,
    KIND_DBL  = 3'd3,
    KIND_TWO  = 3'd4
  } kind_t;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef struct packed {
    kind_t                   kind;
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic signed [CoefW-1:0] c;
  } sq_side_t;

  typedef struct packed {
    kind_t kind;
    logic  neg1;
    logic  neg2;
  } dv_side_t;

  function automatic logic [CoefW-1:0] mag32(input logic [CoefW-1:0] v);
    return v[CoefW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== src/qrs_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit of the integer square root: takes two radicand bits, decides one
// root bit, and hands radicand, remainder and partial root to the next cell.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell
  import qrs_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [RadW-1:0]   rad_i,
  input  logic [SqRemW-1:0] rem_i,
  input  logic [SqrtN-1:0]  root_i,
  output logic [RadW-1:0]   rad_o,
  output logic [SqRemW-1:0] rem_o,
  output logic [SqrtN-1:0]  root_o
);

  logic [SqRemW+1:0] rem_sh;
  logic [SqRemW+1:0] trial;
  logic              ge;
  logic [SqRemW+1:0] diff;

  assign rem_sh = {rem_i, rad_i[RadW-1 -: 2]};
  assign trial  = {{(SqRemW-SqrtN){1'b0}}, root_i, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= {rad_i[RadW-3:0], 2'b00};
      rem_o  <= ge ? diff[SqRemW-1:0] : rem_sh[SqRemW-1:0];
      root_o <= {root_i[SqrtN-2:0], ge};
    end
  end

endmodule

// ===== src/qrs_div_cell.sv =====
// ----------------------------------------------------------------------------
// qrs_div_cell
// One step of restoring division: shifts in one numerator bit, decides one
// quotient bit, and hands the partial result to the next cell.
// ----------------------------------------------------------------------------
module qrs_div_cell
  import qrs_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [DenW-1:0] rem_i,
  input  logic [NumW-1:0] quo_i,
  output logic [NumW-1:0] num_o,
  output logic [DenW-1:0] den_o,
  output logic [DenW-1:0] rem_o,
  output logic [NumW-1:0] quo_o
);

  logic [DenW:0] sh;
  logic [DenW:0] diff;
  logic          ge;

  assign sh   = {rem_i, num_i[NumW-1]};
  assign ge   = sh >= {1'b0, den_i};
  assign diff = sh - {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (en) begin
      num_o <= {num_i[NumW-2:0], 1'b0};
      den_o <= den_i;
      rem_o <= ge ? diff[DenW-1:0] : sh[DenW-1:0];
      quo_o <= {quo_i[NumW-2:0], ge};
    end
  end

endmodule

// ===== src/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2+b*x+c=0, Q16.16 coefficients in, Q32.32 roots out.
//
//   channel | signals                                   | transfer when
//   in      | in_valid, in_stall, coef_quad/lin/const   | in_valid & !in_stall
//   out     | out_valid, out_stall, root_count, roots,  | out_valid & !out_stall
//           | overflow                                  |
//
// One item per cycle while the output is not stalled. Stages: 3 front stages
// (register, products, discriminant), 50 square root cells, one numerator
// stage, 67 divider cells and the output register. Reset clears all valid
// bits. A stalled output holds the whole pipe; in_stall is raised for that cycle.
// ----------------------------------------------------------------------------
module quadratic_root_solver
  import qrs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [CoefW-1:0] coef_quad,
  input  logic signed [CoefW-1:0] coef_lin,
  input  logic signed [CoefW-1:0] coef_const,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              root_count,
  output logic signed [RootW-1:0] first_root,
  output logic signed [RootW-1:0] second_root,
  output logic                    overflow
);

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // front stages
  logic                    v0, v1, v2;
  logic signed [CoefW-1:0] a0, b0, c0, a1, b1, c1;
  logic [2*CoefW-1:0]      bsq1, mac1;
  sq_side_t                side2;
  logic [DiscW-1:0]        d2;

  logic [DiscW-1:0] bsq_x, fac_x, d_next;
  logic             fac_neg, d_neg;
  kind_t            kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0   <= coef_quad;
      b0   <= coef_lin;
      c0   <= coef_const;
      a1   <= a0;
      b1   <= b0;
      c1   <= c0;
      bsq1 <= mag32(b0) * mag32(b0);
      mac1 <= mag32(a0) * mag32(c0);
      side2.kind <= kind_next;
      side2.a    <= a1;
      side2.b    <= b1;
      side2.c    <= c1;
      d2         <= d_next;
    end
  end

  always_comb begin
    bsq_x   = {{(DiscW-2*CoefW){1'b0}}, bsq1};
    fac_x   = {mac1, 2'b00};
    fac_neg = (c1 != '0) && (a1[CoefW-1] != c1[CoefW-1]);
    d_neg   = !fac_neg && (bsq_x < fac_x);
    d_next  = fac_neg ? (bsq_x + fac_x) : (bsq_x - fac_x);
    if (a1 == '0) begin
      if (b1 == '0) begin
        kind_next = (c1 == '0) ? KIND_INF : KIND_NONE;
      end else begin
        kind_next = KIND_LIN;
      end
    end else if (d_neg) begin
      kind_next = KIND_NONE;
    end else if (d_next == '0) begin
      kind_next = KIND_DBL;
    end else begin
      kind_next = KIND_TWO;
    end
  end

  // square root chain
  logic [RadW-1:0]   sq_rad  [0:SqrtN];
  logic [SqRemW-1:0] sq_rem  [0:SqrtN];
  logic [SqrtN-1:0]  sq_root [0:SqrtN];
  sq_side_t          sq_side [0:SqrtN];
  logic              sq_v    [0:SqrtN];

  assign sq_rad[0]  = {{(RadW-DiscW-32){1'b0}}, d2, 32'd0};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = side2;
  assign sq_v[0]    = v2;

  for (genvar i = 0; i < SqrtN; i++) begin : g_sq
    qrs_sqrt_cell u_cell (
      .clk    (clk),
      .en     (adv),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_side[i+1] <= sq_side[i];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[i+1] <= 1'b0;
      end else if (adv) begin
        sq_v[i+1] <= sq_v[i];
      end
    end
  end

  // numerator stage
  sq_side_t              sx;
  logic signed [NegW-1:0] nb, n1, n2, sr;
  logic [NegW-1:0]        m1, m2;
  logic [CoefW-1:0]       ma, mb, mc;
  logic [NumW-1:0]        num1_next, num2_next;
  logic [DenW-1:0]        den_next;
  logic                   neg1_next, neg2_next;

  always_comb begin
    sx  = sq_side[SqrtN];
    ma  = mag32(sx.a);
    mb  = mag32(sx.b);
    mc  = mag32(sx.c);
    sr  = {{(NegW-SqrtN){1'b0}}, sq_root[SqrtN]};
    nb  = -({{(NegW-CoefW){sx.b[CoefW-1]}}, sx.b} <<< 16);
    n1  = nb - sr;
    n2  = nb + sr;
    m1  = n1[NegW-1] ? (~n1 + 1'b1) : n1;
    m2  = n2[NegW-1] ? (~n2 + 1'b1) : n2;
    den_next  = ma;
    num2_next = {m2[NumW-16:0], 15'd0};
    neg2_next = (n2 != '0) && (n2[NegW-1] != sx.a[CoefW-1]);
    case (sx.kind)
      KIND_LIN: begin
        den_next  = mb;
        num1_next = {3'd0, mc, 32'd0};
        neg1_next = (sx.c != '0) && (sx.c[CoefW-1] == sx.b[CoefW-1]);
      end
      KIND_DBL: begin
        num1_next = {4'd0, mb, 31'd0};
        neg1_next = (sx.b != '0) && (sx.b[CoefW-1] == sx.a[CoefW-1]);
      end
      default: begin
        num1_next = {m1[NumW-16:0], 15'd0};
        neg1_next = (n1 != '0) && (n1[NegW-1] != sx.a[CoefW-1]);
      end
    endcase
  end

  // divider chains
  logic [NumW-1:0] d1_num [0:NumW];
  logic [NumW-1:0] d1_quo [0:NumW];
  logic [DenW-1:0] d1_rem [0:NumW];
  logic [DenW-1:0] d1_den [0:NumW];
  logic [NumW-1:0] d2_num [0:NumW];
  logic [NumW-1:0] d2_quo [0:NumW];
  logic [DenW-1:0] d2_rem [0:NumW];
  logic [DenW-1:0] d2_den [0:NumW];
  dv_side_t        dv_side [0:NumW];
  logic            dv_v    [0:NumW];

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_num[0]       <= num1_next;
      d2_num[0]       <= num2_next;
      d1_den[0]       <= den_next;
      d2_den[0]       <= den_next;
      dv_side[0].kind <= sx.kind;
      dv_side[0].neg1 <= neg1_next;
      dv_side[0].neg2 <= neg2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[SqrtN];
    end
  end

  assign d1_quo[0] = '0;
  assign d1_rem[0] = '0;
  assign d2_quo[0] = '0;
  assign d2_rem[0] = '0;

  for (genvar i = 0; i < NumW; i++) begin : g_dv
    qrs_div_cell u_d1 (
      .clk   (clk),
      .en    (adv),
      .num_i (d1_num[i]),
      .den_i (d1_den[i]),
      .rem_i (d1_rem[i]),
      .quo_i (d1_quo[i]),
      .num_o (d1_num[i+1]),
      .den_o (d1_den[i+1]),
      .rem_o (d1_rem[i+1]),
      .quo_o (d1_quo[i+1])
    );
    qrs_div_cell u_d2 (
      .clk   (clk),
      .en    (adv),
      .num_i (d2_num[i]),
      .den_i (d2_den[i]),
      .rem_i (d2_rem[i]),
      .quo_i (d2_quo[i]),
      .num_o (d2_num[i+1]),
      .den_o (d2_den[i+1]),
      .rem_o (d2_rem[i+1]),
      .quo_o (d2_quo[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side[i+1] <= dv_side[i];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[i+1] <= 1'b0;
      end else if (adv) begin
        dv_v[i+1] <= dv_v[i];
      end
    end
  end

  // saturate, sign and output register
  dv_side_t         fs;
  logic [NumW-1:0]  q1, q2;
  logic [RootW-1:0] lim1, lim2, val1, val2, r1_next, r2_next;
  logic             ov1, ov2;
  logic [1:0]       cnt_next;
  logic             has1, has2;

  always_comb begin
    fs   = dv_side[NumW];
    q1   = d1_quo[NumW];
    q2   = d2_quo[NumW];
    lim1 = fs.neg1 ? {1'b1, {(RootW-1){1'b0}}} : {1'b0, {(RootW-1){1'b1}}};
    lim2 = fs.neg2 ? {1'b1, {(RootW-1){1'b0}}} : {1'b0, {(RootW-1){1'b1}}};
    ov1  = (q1[NumW-1:RootW] != '0) || (q1[RootW-1:0] > lim1);
    ov2  = (q2[NumW-1:RootW] != '0) || (q2[RootW-1:0] > lim2);
    val1 = ov1 ? lim1 : q1[RootW-1:0];
    val2 = ov2 ? lim2 : q2[RootW-1:0];
    has1 = 1'b0;
    has2 = 1'b0;
    case (fs.kind)
      KIND_INF: cnt_next = CNT_INF;
      KIND_LIN, KIND_DBL: begin
        cnt_next = CNT_ONE;
        has1     = 1'b1;
      end
      KIND_TWO: begin
        cnt_next = CNT_TWO;
        has1     = 1'b1;
        has2     = 1'b1;
      end
      default: cnt_next = CNT_NONE;
    endcase
    r1_next = !has1 ? '0 : (fs.neg1 ? (~val1 + 1'b1) : val1);
    r2_next = !has2 ? '0 : (fs.neg2 ? (~val2 + 1'b1) : val2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v[NumW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      root_count  <= cnt_next;
      first_root  <= r1_next;
      second_root <= r2_next;
      overflow    <= (has1 && ov1) || (has2 && ov2);
    end
  end

`ifndef SYNTHESIS
  a_ovf_needs_root: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> (root_count == CNT_ONE) || (root_count == CNT_TWO))
    else $error("overflow without a root");

  a_second_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (root_count != CNT_TWO) |-> second_root == '0)
    else $error("second root set without two roots");

  a_no_root_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((root_count == CNT_NONE) || (root_count == CNT_INF))
    |-> (first_root == '0) && !overflow)
    else $error("root data with no finite root");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(first_root))
    else $error("stalled result changed");
`endif

endmodule

// ===== dv/quadratic_root_solver_tb.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver_tb
// Drives coefficient sets through the root solver under random input gaps and
// output stalls, predicts count, roots and overflow with wide integer math,
// and compares every result transfer in order against the predicted queue.
// ----------------------------------------------------------------------------
module quadratic_root_solver_tb
  import qrs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PipeLat  = 122;
  localparam int IdleLim  = 20000;

  typedef struct {
    logic [1:0]  count;
    logic [63:0] r1;
    logic [63:0] r2;
    logic        ovf;
  } roots_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CoefW-1:0] coef_quad = '0;
  logic signed [CoefW-1:0] coef_lin = '0;
  logic signed [CoefW-1:0] coef_const = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] root_count;
  logic signed [RootW-1:0] first_root;
  logic signed [RootW-1:0] second_root;
  logic overflow;

  roots_t roots_q[$];
  int     fail_cnt = 0;
  int     idle_cyc = 0;

  always #1 clk = ~clk;

  quadratic_root_solver u_dut (.*);

  function automatic logic [63:0] sat_root(logic [255:0] num, logic [255:0] den,
                                           logic neg, inout logic ovf);
    logic [255:0] q;
    logic [63:0]  lim;
    q   = num / den;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    if (q > {192'd0, lim}) begin
      ovf = 1'b1;
      q   = {192'd0, lim};
    end
    return neg ? (64'd0 - q[63:0]) : q[63:0];
  endfunction

  function automatic roots_t solve_roots(logic signed [31:0] a, logic signed [31:0] b,
                                         logic signed [31:0] c);
    roots_t       res;
    logic signed [255:0] sa, sb, sc, disc, nb, n1, n2;
    logic [255:0] ma, ds, s, t;
    res = '{default: '0};
    sa = a; sb = b; sc = c;
    ma = sa < 0 ? -sa : sa;
    if (a == 0) begin
      if (b == 0) begin
        res.count = (c == 0) ? CNT_INF : CNT_NONE;
      end else begin
        res.count = CNT_ONE;
        res.r1 = sat_root((sc < 0 ? -sc : sc) << 32, sb < 0 ? -sb : sb,
                          (c != 0) && ((c < 0) == (b < 0)), res.ovf);
      end
    end else begin
      disc = sb * sb - 4 * sa * sc;
      if (disc < 0) begin
        res.count = CNT_NONE;
      end else if (disc == 0) begin
        res.count = CNT_ONE;
        res.r1 = sat_root((sb < 0 ? -sb : sb) << 31, ma,
                          (b != 0) && ((b < 0) == (a < 0)), res.ovf);
      end else begin
        ds = disc << 32;
        s  = '0;
        for (int i = 49; i >= 0; i--) begin
          t = s | (256'd1 << i);
          if (t * t <= ds) s = t;
        end
        nb = -sb * 65536;
        n1 = nb - $signed(s);
        n2 = nb + $signed(s);
        res.count = CNT_TWO;
        res.r1 = sat_root((n1 < 0 ? -n1 : n1) * 32768, ma,
                          (n1 != 0) && ((n1 < 0) != (a < 0)), res.ovf);
        res.r2 = sat_root((n2 < 0 ? -n2 : n2) * 32768, ma,
                          (n2 != 0) && ((n2 < 0) != (a < 0)), res.ovf);
      end
    end
    return res;
  endfunction

  task automatic send_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    coef_quad  <= a;
    coef_lin   <= b;
    coef_const <= c;
    roots_q.push_back(solve_roots(a, b, c));
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      3: return 32'($signed($urandom_range(0, 16))) * 32'sh10000 *
                ($urandom_range(0, 1) ? 1 : -1);
      4: return 32'($urandom_range(0, 255)) - 32'd128;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_special_cases();
    send_coefs(0, 0, 0);
    send_coefs(0, 0, 32'h0001_0000);
    send_coefs(0, 32'h0002_0000, 32'hfffc_0000);
    send_coefs(0, 32'h0000_0001, 32'h7fff_ffff);
    send_coefs(0, 32'h8000_0000, 32'h8000_0000);
    send_coefs(0, 32'hffff_ffff, 32'h0000_0001);
    send_coefs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_coefs(32'h0001_0000, 0, 32'h0001_0000);
    send_coefs(32'h0001_0000, 0, 32'hfffc_0000);
    send_coefs(32'hffff_0000, 32'h0003_0000, 32'hfffe_0000);
    send_coefs(32'h0000_0001, 32'h7fff_ffff, 0);
    send_coefs(32'h0000_0001, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coefs(32'h8000_0000, 0, 0);
    send_coefs(32'h0000_0001, 0, 32'hffff_ffff);
    send_coefs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_coefs(32'h0000_0004, 32'h0000_0004, 32'h0000_0001);
  endtask

  task automatic test_random_coefs(int n);
    logic [31:0] a, b, c, r;
    for (int i = 0; i < n; i++) begin
      a = rand_coef(); b = rand_coef(); c = rand_coef();
      case ($urandom_range(0, 9))
        0: a = 0;
        1: begin a = 0; b = 0; end
        2: begin
          r = 32'($urandom_range(1, 64)) - 32'd32;
          a = 32'h0001_0000;
          b = -2 * r * 32'h0001_0000;
          c = r * r * 32'h0001_0000;
        end
        default: ;
      endcase
      send_coefs(a, b, c);
    end
  endtask

  // draw a stall length for every result, count it down while a result waits
  always @(posedge clk) begin
    int wait_n;
    if (rst) begin
      wait_n = $urandom_range(0, 9);
    end else if (out_valid && !out_stall) begin
      wait_n = $urandom_range(0, 9);
    end else if (out_valid && wait_n > 0) begin
      wait_n--;
    end
    out_stall <= (wait_n != 0);
  end

  always @(posedge clk) begin
    roots_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (roots_q.size() == 0) begin
        $error("result with no expectation");
        fail_cnt++;
      end else begin
        exp_r = roots_q.pop_front();
        if (root_count !== exp_r.count) begin
          $error("root_count exp %0d got %0d", exp_r.count, root_count);
          fail_cnt++;
        end
        if (first_root !== exp_r.r1) begin
          $error("first_root exp %h got %h", exp_r.r1, first_root);
          fail_cnt++;
        end
        if (second_root !== exp_r.r2) begin
          $error("second_root exp %h got %h", exp_r.r2, second_root);
          fail_cnt++;
        end
        if (overflow !== exp_r.ovf) begin
          $error("overflow exp %0d got %0d", exp_r.ovf, overflow);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc > IdleLim) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_cases();
    test_random_coefs(650);
    in_valid <= 1'b0;
    while (roots_q.size() != 0) @(posedge clk);
    repeat (PipeLat + 10) @(posedge clk);
    if (fail_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
src/qrs_pkg.sv
src/qrs_sqrt_cell.sv
src/qrs_div_cell.sv
src/quadratic_root_solver.sv
dv/quadratic_root_solver_tb.sv
